/* rtl/cpts_pkg.sv */
package cpts_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int POS_W        = 32;
    localparam int LOC_W        = 31;
    localparam int OFF_W        = 16;
    localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 31;
    localparam int STEP_W       = $clog2(POS_W);

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd1;

    localparam logic signed [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};
    localparam logic signed [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};

    typedef struct packed {
        logic                     cmd;
        logic [5:0]               entry_index;
        logic [30:0]              entry_start;
        logic [30:0]              entry_end;
        logic                     entry_reversed;
        logic signed [POS_W-1:0]  pos_s;
        logic signed [OFF_W-1:0]  pos_r;
        logic signed [OFF_W-1:0]  pos_h;
    } t_in_item;

    typedef struct packed {
        logic                     hit;
        logic [5:0]               segment_index;
        logic [LOC_W-1:0]         local_s;
        logic signed [OFF_W-1:0]  local_r;
        logic signed [OFF_W-1:0]  local_h;
        logic                     reversed;
    } t_out_item;

    typedef struct packed {
        logic             rev;
        logic [LOC_W-1:0] seg_end;
        logic [LOC_W-1:0] seg_start;
    } t_seg_entry;

endpackage

/* rtl/cpts_ram.sv */
module cpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cpts_mod.sv */
module cpts_mod
    import cpts_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [POS_W-1:0] i_pos,
    input  logic [LOC_W-1:0]        i_cyc,
    output logic                    o_done,
    output logic [LOC_W-1:0]        o_rem
);

    logic              r_busy, n_busy;
    logic              r_fix, n_fix;
    logic              r_done, n_done;
    logic              r_neg, n_neg;
    logic [POS_W-1:0]  r_mag, n_mag;
    logic [LOC_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0] r_cnt, n_cnt;

    logic [POS_W-1:0]  w_abs;
    logic [LOC_W:0]    w_trial;
    logic [LOC_W:0]    w_diff;
    logic              w_ge;

    // magnitude of the most negative value still fits as unsigned
    assign w_abs   = i_pos[POS_W-1] ? (~i_pos + 1'b1) : i_pos;
    // restoring division, one dividend bit per cycle
    assign w_trial = {r_rem, r_mag[POS_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_cyc};
    assign w_diff  = w_trial - {1'b0, i_cyc};

    always_comb begin
        n_busy = r_busy;
        n_fix  = 1'b0;
        n_done = 1'b0;
        n_neg  = r_neg;
        n_mag  = r_mag;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_neg  = i_pos[POS_W-1];
            n_mag  = w_abs;
            n_rem  = '0;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_mag = {r_mag[POS_W-2:0], 1'b0};
            n_rem = w_ge ? w_diff[LOC_W-1:0] : w_trial[LOC_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == STEP_W'(POS_W - 1)) begin
                n_busy = 1'b0;
                n_fix  = 1'b1;
            end
        end else if (r_fix) begin
            // floor modulo: a negative remainder moves up by the cycle length
            if (r_neg && (r_rem != '0)) begin
                n_rem = i_cyc - r_rem;
            end
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fix  <= n_fix;
            r_done <= n_done;
        end
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* rtl/circuit_position_to_segment.sv */
// position to segment projector for a looped track
//
// input channel (i_in_valid / o_in_stall) carries load and project requests.
// a load request writes one entry of the segment table in the cycle it is
// accepted and gives no result. a project request reduces pos_s modulo the
// cycle length in a bit-serial divider with a sign fix and a hand-over step,
// then scans the table one entry per cycle through the table's registered
// read port, stopping at the first entry whose end exceeds the reduced
// position. the scan covers at most entry_count entries, capped at 64; a
// miss gives an all-zero result, as does a request with a zero cycle length,
// which skips the divider and the scan. one request is worked on at a time:
// the next one is taken the cycle after a result is loaded.
// the result sits in an output register: while the receiver stalls, the
// block keeps taking requests and finishes one more, then holds it and stalls
// the input. config writes (i_cfg_*) are always ready; write them only idle.
// reset clears the control state and sets cycle_length and entry_count to 1;
// the table contents stay undefined until loaded.
module circuit_position_to_segment
    import cpts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MOD    = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [LOC_W-1:0]        r_cycle_length;
    logic [CNT_W-1:0]        r_entry_count;
    logic [LOC_W-1:0]        r_pos_rem, n_pos_rem;
    logic signed [OFF_W-1:0] r_r, n_r;
    logic signed [OFF_W-1:0] r_h, n_h;
    logic [CNT_W-1:0]        r_ridx, n_ridx;
    logic                    r_pend, n_pend;
    logic [SEG_IDX_W-1:0]    r_pidx, n_pidx;
    t_out_item               r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out_data, n_out_data;

    logic                    w_mod_start;
    logic                    w_mod_done;
    logic [LOC_W-1:0]        w_mod_rem;
    logic                    w_we;
    t_seg_entry              w_wentry;
    t_seg_entry              w_rentry;
    logic [CNT_W-1:0]        w_limit;
    logic                    w_match;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_limit = (r_entry_count > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                            : r_entry_count;

    assign w_we = (r_state == ST_IDLE) && i_in_valid && (i_in_data.cmd == CMD_LOAD);
    assign w_wentry.rev       = i_in_data.entry_reversed;
    assign w_wentry.seg_end   = i_in_data.entry_end;
    assign w_wentry.seg_start = i_in_data.entry_start;

    cpts_ram #(
        .WIDTH ($bits(t_seg_entry)),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_in_data.entry_index),
        .i_wdata (w_wentry),
        .i_raddr (r_ridx[SEG_IDX_W-1:0]),
        .o_rdata (w_rentry)
    );

    cpts_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_pos   (i_in_data.pos_s),
        .i_cyc   (r_cycle_length),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    assign w_match = r_pend && (r_pos_rem < w_rentry.seg_end);

    always_comb begin
        n_state     = r_state;
        n_pos_rem   = r_pos_rem;
        n_r         = r_r;
        n_h         = r_h;
        n_ridx      = r_ridx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_mod_start = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_in_data.cmd == CMD_PROJECT)) begin
                    n_r = i_in_data.pos_r;
                    n_h = i_in_data.pos_h;
                    if (r_cycle_length == '0) begin
                        n_res   = '0;
                        n_state = ST_DONE;
                    end else begin
                        w_mod_start = 1'b1;
                        n_state     = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (w_mod_done) begin
                    n_pos_rem = w_mod_rem;
                    n_ridx    = '0;
                    n_pend    = 1'b0;
                    n_state   = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // read of entry ridx issued now, compare of entry pidx this cycle
                n_pend = (r_ridx < w_limit);
                if (r_ridx < w_limit) begin
                    n_ridx = r_ridx + 1'b1;
                    n_pidx = r_ridx[SEG_IDX_W-1:0];
                end
                if (w_match) begin
                    n_res.hit           = 1'b1;
                    n_res.segment_index = r_pidx;
                    n_res.local_h       = r_h;
                    n_res.reversed      = w_rentry.rev;
                    if (w_rentry.rev) begin
                        n_res.local_s = w_rentry.seg_end - r_pos_rem;
                        n_res.local_r = (r_r == OFF_MIN) ? OFF_MAX : -r_r;
                    end else begin
                        n_res.local_s = (r_pos_rem >= w_rentry.seg_start)
                                      ? r_pos_rem - w_rentry.seg_start : '0;
                        n_res.local_r = r_r;
                    end
                    n_state = ST_DONE;
                end else if (!r_pend && (r_ridx >= w_limit)) begin
                    n_res   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_pend         <= 1'b0;
            r_cycle_length <= LOC_W'(1);
            r_entry_count  <= CNT_W'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_CYCLE_LENGTH: r_cycle_length <= i_cfg_data[LOC_W-1:0];
                    CFG_ENTRY_COUNT:  r_entry_count  <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_pos_rem  <= n_pos_rem;
        r_r        <= n_r;
        r_h        <= n_h;
        r_ridx     <= n_ridx;
        r_pidx     <= n_pidx;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    a_mod_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == ST_MOD))
        else $error("divider finished outside the modulo phase");

    a_rem_below_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (w_mod_rem < r_cycle_length))
        else $error("reduced position not below cycle length");

    a_compare_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SEARCH) && r_pend) |-> ({1'b0, r_pidx} < w_limit))
        else $error("compared entry beyond the searched range");

    a_done_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && (!r_out_valid || !i_out_stall)) |=> o_out_valid)
        else $error("finished request did not reach the output register");
`endif

endmodule

/* test/tb_top.sv */
module tb_top;
    import cpts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 120;
    localparam int WATCHDOG_LIMIT = 4000;

    // indexes past the two real registers, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_req;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_res;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow copy of the block's table and registers
    logic [LOC_W-1:0] seg_start_tbl [MAX_SEGMENTS];
    logic [LOC_W-1:0] seg_end_tbl   [MAX_SEGMENTS];
    logic             seg_rev_tbl   [MAX_SEGMENTS];
    logic [LOC_W-1:0] loop_len;
    logic [CNT_W-1:0] search_count;

    t_out_item pending_results [$];

    bit idle_en;
    int mismatches = 0;
    int load_cnt;
    int project_cnt;
    int hit_cnt = 0;
    int miss_cnt = 0;
    int reg_writes;
    int quiet_cycles = 0;

    circuit_position_to_segment u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= idle_en && ($urandom_range(99) < 19);
    end

    // floor modulo, then first entry whose end lies past the reduced position
    function automatic t_out_item project_position(t_in_item req);
        t_out_item res;
        longint    pos;
        longint    len;
        longint    rem;
        longint    ls;
        int        n;
        res = '0;
        if (loop_len == 0) return res;
        pos = longint'($signed(req.pos_s));
        len = longint'(loop_len);
        rem = pos % len;
        if (rem < 0) rem += len;
        n = (search_count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(search_count);
        for (int i = 0; i < n; i++) begin
            if (rem < longint'(seg_end_tbl[i])) begin
                res.hit           = 1'b1;
                res.segment_index = SEG_IDX_W'(i);
                res.local_h       = req.pos_h;
                res.reversed      = seg_rev_tbl[i];
                if (seg_rev_tbl[i]) begin
                    ls = longint'(seg_end_tbl[i]) - rem;
                    res.local_r = (req.pos_r == OFF_MIN) ? OFF_MAX : -req.pos_r;
                end else begin
                    ls = rem - longint'(seg_start_tbl[i]);
                    if (ls < 0) ls = 0;
                    res.local_r = req.pos_r;
                end
                res.local_s = LOC_W'(ls);
                return res;
            end
        end
        return res;
    endfunction

    function automatic t_in_item load_item(logic [5:0] slot, logic [30:0] st,
                                           logic [30:0] en, logic rev);
        t_in_item it;
        it.cmd            = CMD_LOAD;
        it.entry_index    = slot;
        it.entry_start    = st;
        it.entry_end      = en;
        it.entry_reversed = rev;
        it.pos_s          = $urandom();
        it.pos_r          = OFF_W'($urandom_range(0, 65535));
        it.pos_h          = OFF_W'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic t_in_item project_item(logic signed [POS_W-1:0] pos,
                                              logic signed [OFF_W-1:0] r,
                                              logic signed [OFF_W-1:0] h);
        t_in_item it;
        it.cmd            = CMD_PROJECT;
        it.entry_index    = 6'($urandom_range(0, 63));
        it.entry_start    = 31'($urandom());
        it.entry_end      = 31'($urandom());
        it.entry_reversed = 1'($urandom_range(0, 1));
        it.pos_s          = pos;
        it.pos_r          = r;
        it.pos_h          = h;
        return it;
    endfunction

    function automatic logic signed [OFF_W-1:0] rand_offset();
        if ($urandom_range(19) == 0) return OFF_MIN;
        return OFF_W'($urandom_range(0, 65535));
    endfunction

    // mostly positions a few loops around zero or next to an entry end
    function automatic logic signed [POS_W-1:0] pick_position(longint len, int n);
        longint v;
        int     idx;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                v = longint'($urandom_range(0, len - 1))
                    + (longint'($urandom_range(0, 3)) - 2) * len;
            end
            4, 5: begin
                idx = $urandom_range(0, n - 1);
                v = longint'(seg_end_tbl[idx]) - longint'($urandom_range(0, 1))
                    + (longint'($urandom_range(0, 2)) - 1) * len;
            end
            default: v = longint'($urandom());
        endcase
        return v[POS_W-1:0];
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with no pending request, expected none actual %p",
                         $time, out_res);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", want.hit, out_res.hit);
                check_field("segment_index", want.segment_index, out_res.segment_index);
                check_field("local_s", want.local_s, out_res.local_s);
                check_field("local_r", want.local_r, out_res.local_r);
                check_field("local_h", want.local_h, out_res.local_h);
                check_field("reversed", want.reversed, out_res.reversed);
                if (want.hit) hit_cnt++;
                else miss_cnt++;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_request(t_in_item req);
        while (idle_en && $urandom_range(99) < 19) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (in_stall);
        if (req.cmd == CMD_LOAD) begin
            seg_start_tbl[req.entry_index] = req.entry_start;
            seg_end_tbl[req.entry_index]   = req.entry_end;
            seg_rev_tbl[req.entry_index]   = req.entry_reversed;
            load_cnt++;
        end else begin
            pending_results = {pending_results, project_position(req)};
            project_cnt++;
        end
    endtask

    // drop valid, drain every pending result, then let a possible load settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_CYCLE_LENGTH) loop_len = data;
        else if (idx == CFG_ENTRY_COUNT) search_count = data[CNT_W-1:0];
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ends spread evenly up to the loop end, the last one sometimes pulled back to len - len/8
    task automatic build_table(longint len, int count);
        int     n;
        longint prev;
        longint en;
        longint st;
        n = (count > MAX_SEGMENTS) ? MAX_SEGMENTS : ((count < 1) ? 1 : count);
        prev = 0;
        for (int i = 0; i < n; i++) begin
            en = (len * (i + 1)) / n;
            if (i == n - 1 && $urandom_range(3) == 0) en = len - len / 8;
            st = ($urandom_range(3) == 0) ? longint'($urandom_range(0, len)) : prev;
            send_request(load_item(6'(i), 31'(st), 31'(en), 1'($urandom_range(0, 1))));
            prev = en;
        end
    endtask

    task automatic fill_segment_table();
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            send_request(load_item(6'(i), 31'($urandom()), 31'($urandom()),
                                   1'($urandom_range(0, 1))));
        end
    endtask

    task automatic test_reset_settings();
        send_request(project_item(0, 0, 0));
        send_request(project_item($urandom(), rand_offset(), rand_offset()));
        send_request(project_item(32'sh8000_0000, OFF_MAX, OFF_MIN));
    endtask

    task automatic test_directed_table();
        wait_idle();
        write_register(CFG_CYCLE_LENGTH, 1000);
        write_register(CFG_ENTRY_COUNT, 4);
        send_request(load_item(0, 0, 100, 1'b0));
        send_request(load_item(1, 100, 300, 1'b1));
        send_request(load_item(2, 450, 600, 1'b0));
        send_request(load_item(3, 600, 900, 1'b1));
        send_request(project_item(0, 0, 0));
        send_request(project_item(99, OFF_MAX, OFF_MIN));
        // reversed entry with the most negative lateral offset
        send_request(project_item(100, OFF_MIN, OFF_MAX));
        send_request(project_item(299, 5, -5));
        // start lies past the position on a forward entry
        send_request(project_item(350, 1, 1));
        send_request(project_item(599, -7, 7));
        send_request(project_item(899, OFF_MAX, 0));
        send_request(project_item(900, 3, 3));
        send_request(project_item(-1, 2, 2));
        send_request(project_item(-1000, 4, 4));
        send_request(project_item(-1001, 6, 6));
        send_request(project_item(32'sh7FFF_FFFF, OFF_MIN, 1));
        send_request(project_item(32'sh8000_0000, 9, OFF_MIN));
    endtask

    task automatic test_register_extremes();
        wait_idle();
        write_register(CFG_CYCLE_LENGTH, 0);
        send_request(project_item($urandom(), rand_offset(), rand_offset()));
        send_request(project_item(0, OFF_MIN, OFF_MAX));
        wait_idle();
        write_register(CFG_CYCLE_LENGTH, 31'h7FFF_FFFF);
        write_register(CFG_ENTRY_COUNT, 64);
        build_table(31'h7FFF_FFFF, 64);
        send_request(project_item(32'sh7FFF_FFFF, rand_offset(), rand_offset()));
        send_request(project_item(32'sh8000_0000, rand_offset(), rand_offset()));
        send_request(project_item(32'sh7FFF_FFFE, OFF_MIN, OFF_MIN));
        wait_idle();
        write_register(CFG_ENTRY_COUNT, 0);
        send_request(project_item(0, 1, 1));
        send_request(project_item($urandom(), rand_offset(), rand_offset()));
        wait_idle();
        // oversize count saturates; spare indexes change nothing
        write_register(CFG_ENTRY_COUNT, 127);
        write_register(CFG_SPARE_A, 31'($urandom()));
        write_register(CFG_SPARE_B, 31'($urandom()));
        send_request(project_item(-1, rand_offset(), rand_offset()));
        send_request(project_item($urandom(), rand_offset(), rand_offset()));
    endtask

    task automatic test_random_traffic();
        longint len;
        int     count;
        int     neff;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin len = 37; count = 5; end
                1: begin len = $urandom_range(1, 5000); count = $urandom_range(1, 64); end
                2: begin len = 31'h7FFF_FFFF; count = 64; end
                3: begin len = $urandom_range(1, 32'h7FFF_FFFF); count = $urandom_range(1, 16); end
                default: begin len = $urandom_range(1, 300); count = 100; end
            endcase
            wait_idle();
            write_register(CFG_CYCLE_LENGTH, 31'(len));
            write_register(CFG_ENTRY_COUNT, 31'(count));
            build_table(len, count);
            neff = (count > MAX_SEGMENTS) ? MAX_SEGMENTS : count;
            // one phase runs with no idling on either side
            idle_en = (p != 2);
            for (int k = 0; k < 60; k++) begin
                if (p == 0 && k < 10) wait_idle();
                if ($urandom_range(99) < 15) begin
                    send_request(load_item(6'($urandom_range(0, 63)), 31'($urandom()),
                                           31'($urandom()), 1'($urandom_range(0, 1))));
                end else begin
                    send_request(project_item(pick_position(len, neff), rand_offset(),
                                              rand_offset()));
                end
            end
            idle_en = 1'b1;
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_req       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_en      = 1'b1;
        loop_len     = 1;
        search_count = 1;
        load_cnt     = 0;
        project_cnt  = 0;
        reg_writes   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        fill_segment_table();
        test_reset_settings();
        test_directed_table();
        test_register_extremes();
        test_random_traffic();
        wait_idle();

        $display("covered %0d loads, %0d projections (%0d hits, %0d misses), %0d register writes",
                 load_cnt, project_cnt, hit_cnt, miss_cnt, reg_writes);
        $display("registers ran from reset values through zero and full loop lengths, zero and oversize counts");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/cpts_pkg.sv
rtl/cpts_ram.sv
rtl/cpts_mod.sv
rtl/circuit_position_to_segment.sv
test/tb_top.sv
